// ===== src/stli_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the interpolator.
package stli_pkg;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int unsigned DATA_W    = 16;
  localparam int unsigned ENTRY_W   = 2 * DATA_W;
  localparam int unsigned DIFF_W    = DATA_W + 1;
  localparam int unsigned PROD_W    = 2 * DIFF_W;
  localparam int unsigned MAG_W     = 2 * DATA_W;
  localparam int unsigned SUM_W     = DATA_W + 3;
  localparam int unsigned DIV_CNT_W = $clog2(MAG_W);

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  // read address source
  typedef enum logic [1:0] {
    RD_FIRST = 2'd0,
    RD_LAST  = 2'd1,
    RD_UP    = 2'd2,
    RD_DOWN  = 2'd3
  } rd_sel_e;

  // write address/data source
  typedef enum logic [1:0] {
    WR_SHIFT    = 2'd0,
    WR_NEW_UP   = 2'd1,
    WR_NEW_BASE = 2'd2
  } wr_sel_e;

  typedef enum logic [1:0] {
    Y_ZERO   = 2'd0,
    Y_MATCH  = 2'd1,
    Y_INTERP = 2'd2
  } ysel_e;

  typedef struct packed {
    logic    capture;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    cnt_clr;
    logic    cnt_inc;
    logic    prev_load;
    logic    mul_load;
    logic    div_start;
    logic    pend_load;
    status_e pend_status;
    ysel_e   pend_ysel;
    logic    res_load;
  } ctl_t;

  typedef struct packed {
    op_e  op;
    logic full;
    logic empty;
    logic x_eq;
    logic x_gt;
    logic idx_zero;
    logic idx_last;
    logic div_done;
  } sts_t;

endpackage

// ===== src/sorted_table_linear_interpolator_unit.sv =====
// Top level of the sorted breakpoint table with piecewise linear interpolation.
// One beat in flight. The accepted beat is decoded; clear, no-op, refused insert and empty-table
// query then load their result. An insert moves one RAM entry per cycle while it shifts larger
// points up, and a query scans one entry per cycle, then runs a bit-serial divide. The next
// beat is taken in the cycle after the result loads, later while a held result is stalled.
// Reset empties the table (count to zero only).
module sorted_table_linear_interpolator_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // request channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         operation_i,
  input  logic signed [stli_pkg::DATA_W-1:0] x_value_i,
  input  logic signed [stli_pkg::DATA_W-1:0] y_value_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [stli_pkg::DATA_W-1:0] y_result_o,
  output logic [1:0]                         status_o
);
  import stli_pkg::*;

  // Controller issues one command word per cycle; datapath returns compare
  // and count flags. The result beat sits in an output register, so the
  // controller goes back to idle as soon as that register is free.
  ctl_t ctl;
  sts_t sts;

  stli_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  // Datapath: {x, y} entries live in one RAM kept sorted by x. Inserts walk
  // down from the top entry shifting larger points up; queries walk up from
  // entry zero to find the bracket, then multiply once and divide serially.
  stli_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .sts_o      (sts),
    .operation_i(operation_i),
    .x_value_i  (x_value_i),
    .y_value_i  (y_value_i),
    .y_result_o (y_result_o),
    .status_o   (status_o)
  );

endmodule

// ===== src/stli_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
module stli_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/stli_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module stli_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [stli_pkg::MAG_W-1:0]    dividend_i,
  input  logic [stli_pkg::DATA_W-1:0]   divisor_i,
  output logic                          done_o,
  output logic [stli_pkg::MAG_W-1:0]    quotient_o
);
  import stli_pkg::*;

  logic                 busy_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DATA_W-1:0]    rem_q;
  logic [MAG_W-1:0]     quo_q;
  logic [DATA_W-1:0]    div_q;
  logic [DIFF_W-1:0]    trial;
  logic [DIFF_W-1:0]    trial_sub;
  logic                 fits;

  assign trial     = {rem_q, quo_q[MAG_W-1]};
  assign fits      = trial >= {1'b0, div_q};
  assign trial_sub = trial - {1'b0, div_q};
  assign done_o    = busy_q && (cnt_q == DIV_CNT_W'(MAG_W - 1));
  assign quotient_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + DIV_CNT_W'(1);
      if (done_o) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      div_q <= divisor_i;
    end else if (busy_q) begin
      // remainder stays below the divisor, so the low bits hold it
      rem_q <= fits ? trial_sub[DATA_W-1:0] : trial[DATA_W-1:0];
      quo_q <= {quo_q[MAG_W-2:0], fits};
    end
  end

endmodule

// ===== src/stli_dp.sv =====
// Datapath: breakpoint RAM, scan registers, multiplier, divider and result registers.
module stli_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  stli_pkg::ctl_t                    ctl_i,
  output stli_pkg::sts_t                    sts_o,
  input  logic [1:0]                        operation_i,
  input  logic signed [stli_pkg::DATA_W-1:0] x_value_i,
  input  logic signed [stli_pkg::DATA_W-1:0] y_value_i,
  output logic signed [stli_pkg::DATA_W-1:0] y_result_o,
  output logic [1:0]                        status_o
);
  import stli_pkg::*;

  localparam logic signed [SUM_W-1:0] SatHi = SUM_W'(2 ** (DATA_W - 1) - 1);
  localparam logic signed [SUM_W-1:0] SatLo = -SatHi - SUM_W'(1);

  op_e                      op_q;
  logic signed [DATA_W-1:0] x_q, y_q;
  logic [CNT_W-1:0]         count_q;
  logic [ADDR_W-1:0]        idx_q;
  logic signed [DATA_W-1:0] prev_x_q, prev_y_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [DATA_W-1:0]        den_q;
  logic signed [DATA_W-1:0] pend_y_q, res_y_q;
  status_e                  pend_st_q, res_st_q;

  logic [ADDR_W-1:0]        rd_addr, wr_addr;
  logic [ENTRY_W-1:0]       rdata, wdata;
  logic signed [DATA_W-1:0] rd_x, rd_y;

  logic signed [DIFF_W-1:0] dx, dy, dx_span;
  logic                     prod_neg;
  logic [PROD_W-1:0]        prod_abs;
  logic                     div_done;
  logic [MAG_W-1:0]         quotient;
  logic signed [SUM_W-1:0]  q_ext, q_sgn, y0_ext, sum;
  logic signed [DATA_W-1:0] interp_y;

  // ---- breakpoint store: {x, y} per entry ----
  always_comb begin
    unique case (ctl_i.rd_sel)
      RD_FIRST: rd_addr = '0;
      RD_LAST:  rd_addr = ADDR_W'(count_q - CNT_W'(1));
      RD_UP:    rd_addr = idx_q + ADDR_W'(1);
      RD_DOWN:  rd_addr = idx_q - ADDR_W'(1);
    endcase
  end

  always_comb begin
    unique case (ctl_i.wr_sel)
      WR_SHIFT: begin
        wr_addr = idx_q + ADDR_W'(1);
        wdata   = rdata;
      end
      WR_NEW_UP: begin
        wr_addr = idx_q + ADDR_W'(1);
        wdata   = {x_q, y_q};
      end
      WR_NEW_BASE: begin
        wr_addr = '0;
        wdata   = {x_q, y_q};
      end
      default: begin
        wr_addr = '0;
        wdata   = {x_q, y_q};
      end
    endcase
  end

  stli_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table_ram (
    .clk_i  (clk_i),
    .we_i   (ctl_i.wr_en),
    .waddr_i(wr_addr),
    .wdata_i(wdata),
    .raddr_i(rd_addr),
    .rdata_o(rdata)
  );

  assign rd_x = rdata[ENTRY_W-1:DATA_W];
  assign rd_y = rdata[DATA_W-1:0];

  // ---- interpolation arithmetic ----
  assign dx      = DIFF_W'(x_q) - DIFF_W'(prev_x_q);
  assign dy      = DIFF_W'(rd_y) - DIFF_W'(prev_y_q);
  assign dx_span = DIFF_W'(rd_x) - DIFF_W'(prev_x_q);

  assign prod_neg = prod_q[PROD_W-1];
  assign prod_abs = prod_neg ? PROD_W'(-prod_q) : PROD_W'(prod_q);

  stli_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (ctl_i.div_start),
    .dividend_i(prod_abs[MAG_W-1:0]),
    .divisor_i (den_q),
    .done_o    (div_done),
    .quotient_o(quotient)
  );

  // quotient magnitude is below |y1 - y0|, so DIFF_W bits carry it
  assign q_ext  = $signed({{(SUM_W - DIFF_W){1'b0}}, quotient[DIFF_W-1:0]});
  assign q_sgn  = prod_neg ? -q_ext : q_ext;
  assign y0_ext = SUM_W'(prev_y_q);
  assign sum    = y0_ext + q_sgn;

  always_comb begin
    priority if (sum > SatHi) begin
      interp_y = SatHi[DATA_W-1:0];
    end else if (sum < SatLo) begin
      interp_y = SatLo[DATA_W-1:0];
    end else begin
      interp_y = sum[DATA_W-1:0];
    end
  end

  // ---- registers ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ctl_i.cnt_clr) begin
      count_q <= '0;
    end else if (ctl_i.cnt_inc) begin
      count_q <= count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      op_q <= op_e'(operation_i);
      x_q  <= x_value_i;
      y_q  <= y_value_i;
    end
    if (ctl_i.rd_en) begin
      idx_q <= rd_addr;
    end
    if (ctl_i.prev_load) begin
      prev_x_q <= rd_x;
      prev_y_q <= rd_y;
    end
    if (ctl_i.mul_load) begin
      prod_q <= dx * dy;
      den_q  <= dx_span[DATA_W-1:0];
    end
    if (ctl_i.pend_load) begin
      pend_st_q <= ctl_i.pend_status;
      unique case (ctl_i.pend_ysel)
        Y_ZERO:   pend_y_q <= '0;
        Y_MATCH:  pend_y_q <= rd_y;
        Y_INTERP: pend_y_q <= interp_y;
        default:  pend_y_q <= '0;
      endcase
    end
    if (ctl_i.res_load) begin
      res_y_q  <= pend_y_q;
      res_st_q <= pend_st_q;
    end
  end

  // ---- status to controller ----
  always_comb begin
    sts_o.op       = op_q;
    sts_o.full     = count_q == CNT_W'(TABLE_DEPTH);
    sts_o.empty    = count_q == '0;
    sts_o.x_eq     = rd_x == x_q;
    sts_o.x_gt     = rd_x > x_q;
    sts_o.idx_zero = idx_q == '0;
    sts_o.idx_last = (CNT_W'(idx_q) + CNT_W'(1)) == count_q;
    sts_o.div_done = div_done;
  end

  assign y_result_o = res_y_q;
  assign status_o   = res_st_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("point count beyond table depth");

  a_no_grow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.cnt_inc |-> !sts_o.full)
    else $error("insert committed into a full table");

  a_bracket: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.mul_load |-> (prev_x_q < x_q) && (x_q < rd_x))
    else $error("query x not strictly inside bracket");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.div_start |-> den_q != '0)
    else $error("divide started with zero span");

  a_quo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.pend_load && (ctl_i.pend_ysel == Y_INTERP)) |->
      quotient[MAG_W-1:DIFF_W] == '0)
    else $error("quotient exceeds slope bound");

endmodule

// ===== src/stli_ctrl.sv =====
// Controller FSM: sequences insert shifts, query scans, divide and result handoff.
module stli_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  stli_pkg::sts_t sts_i,
  output stli_pkg::ctl_t ctl_o
);
  import stli_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_DECODE    = 9'b000000010,
    S_INS_SCAN  = 9'b000000100,
    S_INS_PUT   = 9'b000001000,
    S_QRY_SCAN  = 9'b000010000,
    S_DIV_START = 9'b000100000,
    S_DIV_WAIT  = 9'b001000000,
    S_FIX       = 9'b010000000,
    S_DONE      = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts_i.op)
          OP_CLEAR: begin
            ctl_o.cnt_clr     = 1'b1;
            ctl_o.pend_load   = 1'b1;
            ctl_o.pend_status = ST_OK;
            ctl_o.pend_ysel   = Y_ZERO;
            state_d           = S_DONE;
          end
          OP_INSERT: begin
            priority if (sts_i.full) begin
              ctl_o.pend_load   = 1'b1;
              ctl_o.pend_status = ST_FULL;
              ctl_o.pend_ysel   = Y_ZERO;
              state_d           = S_DONE;
            end else if (sts_i.empty) begin
              state_d = S_INS_PUT;
            end else begin
              ctl_o.rd_en  = 1'b1;
              ctl_o.rd_sel = RD_LAST;
              state_d      = S_INS_SCAN;
            end
          end
          OP_QUERY: begin
            if (sts_i.empty) begin
              ctl_o.pend_load   = 1'b1;
              ctl_o.pend_status = ST_EMPTY;
              ctl_o.pend_ysel   = Y_ZERO;
              state_d           = S_DONE;
            end else begin
              ctl_o.rd_en  = 1'b1;
              ctl_o.rd_sel = RD_FIRST;
              state_d      = S_QRY_SCAN;
            end
          end
          OP_NOP: begin
            ctl_o.pend_load   = 1'b1;
            ctl_o.pend_status = ST_OK;
            ctl_o.pend_ysel   = Y_ZERO;
            state_d           = S_DONE;
          end
        endcase
      end
      // walk down from the top, moving larger entries up one slot
      S_INS_SCAN: begin
        ctl_o.wr_en = 1'b1;
        if (sts_i.x_gt) begin
          ctl_o.wr_sel = WR_SHIFT;
          if (sts_i.idx_zero) begin
            state_d = S_INS_PUT;
          end else begin
            ctl_o.rd_en  = 1'b1;
            ctl_o.rd_sel = RD_DOWN;
          end
        end else begin
          ctl_o.wr_sel      = WR_NEW_UP;
          ctl_o.cnt_inc     = 1'b1;
          ctl_o.pend_load   = 1'b1;
          ctl_o.pend_status = ST_OK;
          ctl_o.pend_ysel   = Y_ZERO;
          state_d           = S_DONE;
        end
      end
      S_INS_PUT: begin
        ctl_o.wr_en       = 1'b1;
        ctl_o.wr_sel      = WR_NEW_BASE;
        ctl_o.cnt_inc     = 1'b1;
        ctl_o.pend_load   = 1'b1;
        ctl_o.pend_status = ST_OK;
        ctl_o.pend_ysel   = Y_ZERO;
        state_d           = S_DONE;
      end
      // walk up until the first entry at or above x
      S_QRY_SCAN: begin
        priority if (sts_i.x_eq) begin
          ctl_o.pend_load   = 1'b1;
          ctl_o.pend_status = ST_OK;
          ctl_o.pend_ysel   = Y_MATCH;
          state_d           = S_DONE;
        end else if (sts_i.x_gt) begin
          if (sts_i.idx_zero) begin
            ctl_o.pend_load   = 1'b1;
            ctl_o.pend_status = ST_RANGE;
            ctl_o.pend_ysel   = Y_ZERO;
            state_d           = S_DONE;
          end else begin
            ctl_o.mul_load = 1'b1;
            state_d        = S_DIV_START;
          end
        end else if (sts_i.idx_last) begin
          ctl_o.pend_load   = 1'b1;
          ctl_o.pend_status = ST_RANGE;
          ctl_o.pend_ysel   = Y_ZERO;
          state_d           = S_DONE;
        end else begin
          ctl_o.prev_load = 1'b1;
          ctl_o.rd_en     = 1'b1;
          ctl_o.rd_sel    = RD_UP;
        end
      end
      S_DIV_START: begin
        ctl_o.div_start = 1'b1;
        state_d         = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (sts_i.div_done) begin
          state_d = S_FIX;
        end
      end
      S_FIX: begin
        ctl_o.pend_load   = 1'b1;
        ctl_o.pend_status = ST_OK;
        ctl_o.pend_ysel   = Y_INTERP;
        state_d           = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          ctl_o.res_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = ctl_o.res_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;

endmodule
